### sv/trm_pkg.sv
// Package for the traceroute reply matcher.
// Holds the field widths, protocol constants and the parse result struct.
// No dependencies.
package trm_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;
   localparam int TABLE_DEPTH = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_ID  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_TTL = 1'b1;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [7:0] TYPE_ECHO          = 8'd8;
   localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] QUOTE_SKIP         = 8'd8;
   localparam logic [7:0] ID_OFFSET          = 8'd4;
   localparam logic [7:0] SRC_FIRST_POS      = 8'd12;
   localparam logic [7:0] SRC_LAST_POS       = 8'd15;
   localparam logic [7:0] POS_MAX            = 8'd255;

   typedef struct packed {
      logic        fields_ok;
      logic [15:0] reply_id;
      logic [15:0] reply_seq;
      logic [31:0] source_addr;
   } parse_type;

endpackage

### sv/trm_parser.sv
// Per-packet header parser of the traceroute reply matcher.
// Tracks the byte position and extracts source address, id and sequence.
// Depends on trm_pkg.
module trm_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               cmd,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output trm_pkg::parse_type res
);

   logic [7:0]  pos_ff, pos_in;
   logic [5:0]  ohl_ff, ohl_in, ohl_tb;
   logic [7:0]  type_ff, type_in, type_tb;
   logic [5:0]  ihl_ff, ihl_in, ihl_tb;
   logic [15:0] id_ff, id_in, id_tb;
   logic [15:0] seq_ff, seq_in, seq_tb;
   logic [31:0] src_ff, src_in, src_tb;
   logic        fc_ff, fc_in, fc_tb;
   logic [7:0]  base;
   logic [7:0]  field_pos;
   logic        restart;

   always_comb begin
      ohl_tb  = ohl_ff;
      src_tb  = src_ff;
      type_tb = type_ff;
      ihl_tb  = ihl_ff;
      id_tb   = id_ff;
      seq_tb  = seq_ff;
      fc_tb   = fc_ff;
      base    = 8'({2'b00, ohl_ff}) + trm_pkg::QUOTE_SKIP;

      if (pos_ff == 8'd0) begin
         ohl_tb = {data_byte[3:0], 2'b00};
      end
      if (pos_ff >= trm_pkg::SRC_FIRST_POS && pos_ff <= trm_pkg::SRC_LAST_POS) begin
         unique case (pos_ff[1:0])
            2'd0: src_tb[31:24] = src_ff[31:24] | data_byte;
            2'd1: src_tb[23:16] = src_ff[23:16] | data_byte;
            2'd2: src_tb[15:8]  = src_ff[15:8]  | data_byte;
            2'd3: src_tb[7:0]   = src_ff[7:0]   | data_byte;
            default: src_tb = src_ff;
         endcase
      end
      if (pos_ff == {2'b00, ohl_tb}) begin
         type_tb = data_byte;
      end

      if (type_tb == trm_pkg::TYPE_TIME_EXCEEDED) begin
         base = {2'b00, ohl_tb} + trm_pkg::QUOTE_SKIP;
         if (pos_ff == base) begin
            ihl_tb = {data_byte[3:0], 2'b00};
         end
         field_pos = base + {2'b00, ihl_tb} + trm_pkg::ID_OFFSET;
      end else begin
         field_pos = {2'b00, ohl_tb} + trm_pkg::ID_OFFSET;
      end

      if (pos_ff == field_pos) begin
         id_tb[7:0] = data_byte;
      end else if (pos_ff == field_pos + 8'd1) begin
         id_tb[15:8] = data_byte;
      end else if (pos_ff == field_pos + 8'd2) begin
         seq_tb[7:0] = data_byte;
      end else if (pos_ff == field_pos + 8'd3) begin
         seq_tb[15:8] = data_byte;
         fc_tb        = 1'b1;
      end
   end

   assign res.fields_ok   = fc_tb && (pos_ff >= trm_pkg::SRC_LAST_POS)
                            && (type_tb != trm_pkg::TYPE_ECHO);
   assign res.reply_id    = id_tb;
   assign res.reply_seq   = seq_tb;
   assign res.source_addr = src_tb;

   assign restart = (cmd == trm_pkg::CMD_CLEAR) || last_byte;

   always_comb begin
      pos_in  = pos_ff;
      ohl_in  = ohl_ff;
      type_in = type_ff;
      ihl_in  = ihl_ff;
      id_in   = id_ff;
      seq_in  = seq_ff;
      src_in  = src_ff;
      fc_in   = fc_ff;
      if (en) begin
         if (restart) begin
            pos_in  = 8'd0;
            ohl_in  = 6'd0;
            type_in = 8'd0;
            ihl_in  = 6'd0;
            id_in   = 16'd0;
            seq_in  = 16'd0;
            src_in  = 32'd0;
            fc_in   = 1'b0;
         end else begin
            pos_in  = (pos_ff == trm_pkg::POS_MAX) ? pos_ff : pos_ff + 8'd1;
            ohl_in  = ohl_tb;
            type_in = type_tb;
            ihl_in  = ihl_tb;
            id_in   = id_tb;
            seq_in  = seq_tb;
            src_in  = src_tb;
            fc_in   = fc_tb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 8'd0;
         ohl_ff  <= 6'd0;
         type_ff <= 8'd0;
         ihl_ff  <= 6'd0;
         id_ff   <= 16'd0;
         seq_ff  <= 16'd0;
         src_ff  <= 32'd0;
         fc_ff   <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         ohl_ff  <= ohl_in;
         type_ff <= type_in;
         ihl_ff  <= ihl_in;
         id_ff   <= id_in;
         seq_ff  <= seq_in;
         src_ff  <= src_in;
         fc_ff   <= fc_in;
      end
   end

endmodule

### sv/traceroute_reply_matcher_unit.sv
// Top level of the traceroute reply matcher.
// Registers input transactions, tracks matches and senders per round.
// Depends on trm_pkg and trm_parser.
//
//   Channel   Direction  Transaction carries
//   req_      in         tuser: cmd, tdata: data_byte, tlast: last_byte
//   rsp_      out        tdata: matched, response_count, unique_count,
//                        new_sender, sender_addr
//   csr_      in         probe_id (index 0), probe_ttl (index 1)
//
// One byte is accepted per cycle unless a stalled result holds a final byte;
// a result is registered when the final byte leaves the input register.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled result holds the input register only when it holds a final byte.
module traceroute_reply_matcher_unit #(
   parameter int MAX_RESPONSES = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte
   input  logic                            req_tuser,   // cmd
   input  logic                            req_tlast,   // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // matched, response_count, unique_count, new_sender, sender_addr, zero pad
   output logic [trm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [trm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [trm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] RESP_CAP = 2'((MAX_RESPONSES < trm_pkg::TABLE_DEPTH) ?
                                        MAX_RESPONSES : trm_pkg::TABLE_DEPTH);
   localparam logic [1:0] DEPTH_CODE = 2'(trm_pkg::TABLE_DEPTH);

   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_free;
   logic        fire;
   logic        is_final;
   logic        is_clear;

   logic [15:0] probe_id_ff;
   logic [13:0] probe_ttl_ff;

   trm_pkg::parse_type prs;

   logic        matched;
   logic        seen;
   logic        take;
   logic        add;
   logic [1:0]  resp_ff, resp_in;
   logic [1:0]  dist_ff, dist_in;
   logic [31:0] table_ff [trm_pkg::TABLE_DEPTH];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [trm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_clear   = (in_cmd_ff == trm_pkg::CMD_CLEAR);
   assign is_final   = in_valid_ff && !is_clear && in_last_ff;
   assign fire       = in_valid_ff && (!is_final || out_free);
   assign req_tready = !in_valid_ff || fire;

   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_id_ff  <= 16'd0;
         probe_ttl_ff <= 14'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            trm_pkg::CSR_PROBE_ID:  probe_id_ff  <= csr_wdata[15:0];
            trm_pkg::CSR_PROBE_TTL: probe_ttl_ff <= csr_wdata[13:0];
            default: probe_id_ff <= probe_id_ff;
         endcase
      end
   end

   trm_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .en        (fire),
      .cmd       (in_cmd_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .res       (prs)
   );

   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < trm_pkg::TABLE_DEPTH; i++) begin
         if ((2'(i) < dist_ff) && (table_ff[i] == prs.source_addr)) begin
            seen = 1'b1;
         end
      end
   end

   assign matched = prs.fields_ok && (prs.reply_id == probe_id_ff)
                    && (prs.reply_seq[15:2] == probe_ttl_ff);
   assign take    = fire && is_final && matched && (resp_ff < RESP_CAP);
   assign add     = take && !seen && (dist_ff < DEPTH_CODE);

   always_comb begin
      resp_in = resp_ff;
      dist_in = dist_ff;
      if (fire && is_clear) begin
         resp_in = 2'd0;
         dist_in = 2'd0;
      end else begin
         if (take) begin
            resp_in = resp_ff + 2'd1;
         end
         if (add) begin
            dist_in = dist_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_ff <= 2'd0;
         dist_ff <= 2'd0;
      end else begin
         resp_ff <= resp_in;
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < trm_pkg::TABLE_DEPTH; i++) begin
         if (add && (dist_ff == 2'(i))) begin
            table_ff[i] <= prs.source_addr;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && is_final) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_final) begin
         rsp_data_ff <= {2'b00, prs.source_addr, add, dist_in, resp_in, matched};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/trm_checker.sv
// Port checker for the traceroute reply matcher, bound to the top level.
// Watches the result channel for handshake and count consistency.
// Depends on trm_pkg and traceroute_reply_matcher_unit.
module trm_checker #(
   parameter int MAX_RESPONSES = 3
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [trm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam logic [1:0] RESP_CAP = 2'((MAX_RESPONSES < trm_pkg::TABLE_DEPTH) ?
                                        MAX_RESPONSES : trm_pkg::TABLE_DEPTH);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Stalled result transaction changed.");

   a_unique_le_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:3] <= rsp_tdata[2:1]) && (rsp_tdata[2:1] <= RESP_CAP))
      else $error("Sender or response count out of range.");

   a_new_sender: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[5]) |-> (rsp_tdata[0] && (rsp_tdata[4:3] != 2'd0)))
      else $error("New sender reported without a match.");

endmodule

bind traceroute_reply_matcher_unit trm_checker #(.MAX_RESPONSES(MAX_RESPONSES)) u_trm_checker (
   .*
);

### verif/traceroute_reply_matcher_unit_tb.sv
// Self-checking testbench for traceroute_reply_matcher_unit: streams IPv4 packet
// bytes, predicts each per-packet result in place and checks every result field.
// Depends on trm_pkg and the traceroute_reply_matcher_unit RTL.
module traceroute_reply_matcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RSP = 3;
   localparam int REPLY_CAP = (MAX_RSP < trm_pkg::TABLE_DEPTH) ? MAX_RSP
                                                                : trm_pkg::TABLE_DEPTH;
   localparam int NUM_PHASES = 5;
   localparam int PHASE_ITEMS = 220;
   localparam int POOL_SIZE = 5;
   localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

   typedef struct {
      logic       cmd;
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct {
      logic        matched;
      logic [1:0]  responses;
      logic [1:0]  senders;
      logic        fresh;
      logic [31:0] addr;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;            // data_byte
   logic req_tuser = trm_pkg::CMD_BYTE;      // cmd
   logic req_tlast = 1'b0;                   // last_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // matched, response_count, unique_count, new_sender, sender_addr, zero pad
   logic [trm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [trm_pkg::CSR_INDEX_W-1:0] csr_index = trm_pkg::CSR_PROBE_ID;
   logic [trm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   traceroute_reply_matcher_unit #(.MAX_RESPONSES(MAX_RSP)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   byte_item_type byte_feed[$];
   reply_type pending_replies[$];

   logic [15:0] cfg_id = 16'h0000;
   logic [13:0] cfg_ttl = 14'd1;

   int cur_pos = 0;
   int hdr_len = 0;
   int quoted_len = 0;
   logic [7:0] pkt_type = 8'h00;
   logic [15:0] got_id = 16'h0000;
   logic [15:0] got_seq = 16'h0000;
   logic [31:0] src_word = 32'h0;
   logic fields_seen = 1'b0;
   int round_replies = 0;
   int round_senders = 0;
   logic [31:0] sender_seen [0:trm_pkg::TABLE_DEPTH-1];

   int tx_gap_max = 0;
   int rx_stall_max = 0;
   int burst_left = 0;
   int gap_left = 0;
   int run_left = 0;
   byte_item_type next_item;

   int n_items = 0;
   int n_clears = 0;
   int n_results = 0;
   int n_matches = 0;
   int n_fresh = 0;
   int mismatches = 0;

   logic [31:0] sender_pool [0:POOL_SIZE-1];
   logic [7:0] compact_reply [0:15] = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hA8, 8'h00, 8'h01};

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic clear_packet_state();
      cur_pos = 0;
      hdr_len = 0;
      quoted_len = 0;
      pkt_type = 8'h00;
      got_id = 16'h0000;
      got_seq = 16'h0000;
      src_word = 32'h0;
      fields_seen = 1'b0;
   endtask

   // Tracks one accepted transaction and queues the result it produces.
   task automatic follow_byte(input logic cmd, input logic [7:0] b, input logic last);
      int p;
      int base;
      int fpos;
      logic hit;
      logic seen;
      reply_type r;
      if (cmd == trm_pkg::CMD_CLEAR) begin
         clear_packet_state();
         round_replies = 0;
         round_senders = 0;
         n_clears++;
      end else begin
         p = cur_pos;
         if (p == 0) hdr_len = int'(b[3:0]) * 4;
         if (p >= 12 && p <= 15) src_word[8*(15-p) +: 8] = b;
         if (p == hdr_len) pkt_type = b;
         if (pkt_type == trm_pkg::TYPE_TIME_EXCEEDED) begin
            base = hdr_len + int'(trm_pkg::QUOTE_SKIP);
            if (p == base) quoted_len = int'(b[3:0]) * 4;
            fpos = base + quoted_len + int'(trm_pkg::ID_OFFSET);
         end else begin
            fpos = hdr_len + int'(trm_pkg::ID_OFFSET);
         end
         if (p == fpos) got_id[7:0] = b;
         else if (p == fpos + 1) got_id[15:8] = b;
         else if (p == fpos + 2) got_seq[7:0] = b;
         else if (p == fpos + 3) begin
            got_seq[15:8] = b;
            fields_seen = 1'b1;
         end
         if (cur_pos < int'(trm_pkg::POS_MAX)) cur_pos++;
         if (last) begin
            hit = fields_seen && p >= int'(trm_pkg::SRC_LAST_POS)
                  && pkt_type != trm_pkg::TYPE_ECHO
                  && got_id == cfg_id && got_seq[15:2] == cfg_ttl;
            r.fresh = 1'b0;
            if (hit && round_replies < REPLY_CAP) begin
               seen = 1'b0;
               for (int i = 0; i < round_senders; i++)
                  if (sender_seen[i] == src_word) seen = 1'b1;
               if (!seen && round_senders < trm_pkg::TABLE_DEPTH) begin
                  sender_seen[round_senders] = src_word;
                  round_senders++;
                  r.fresh = 1'b1;
               end
               round_replies++;
            end
            r.matched = hit;
            r.responses = 2'(round_replies);
            r.senders = 2'(round_senders);
            r.addr = src_word;
            pending_replies.push_back(r);
            clear_packet_state();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            follow_byte(req_tuser, req_tdata, req_tlast);
            n_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
               next_item = byte_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item.cmd;
               req_tdata <= next_item.data;
               req_tlast <= next_item.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
      end else if (rx_stall_max == 0) begin
         rsp_tready <= 1'b1;
      end else if (!rsp_tready) begin
         rsp_tready <= 1'b1;
         run_left = $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b0;
         run_left = $urandom_range(0, rx_stall_max - 1);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s of result %0d: expected %h, got %h",
                     name, n_results, want, got);
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result transaction, data %h", rsp_tdata);
         end else begin
            want = pending_replies.pop_front();
            check_field("matched", 32'(want.matched), 32'(rsp_tdata[0]));
            check_field("response_count", 32'(want.responses), 32'(rsp_tdata[2:1]));
            check_field("unique_count", 32'(want.senders), 32'(rsp_tdata[4:3]));
            check_field("new_sender", 32'(want.fresh), 32'(rsp_tdata[5]));
            check_field("sender_addr", want.addr, rsp_tdata[37:6]);
            if (want.matched) n_matches++;
            if (want.fresh) n_fresh++;
         end
         n_results++;
      end
   end

   task automatic add_item(input logic cmd, input logic [7:0] b, input logic last);
      byte_item_type it;
      it.cmd = cmd;
      it.data = b;
      it.last = last;
      byte_feed.push_back(it);
   endtask

   function automatic int pick_ihl();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 5;
      if (r < 9) return $urandom_range(6, 15);
      return $urandom_range(0, 4);
   endfunction

   // Builds one reply-like packet and returns the number of bytes queued.
   task automatic add_packet(output int count);
      logic [7:0] pkt [0:299];
      logic [7:0] kind;
      logic [15:0] id;
      logic [13:0] ttl;
      logic [31:0] src;
      int ohl;
      int base;
      int fpos;
      int full;
      int len;
      int r;
      for (int i = 0; i < 300; i++) pkt[i] = 8'($urandom_range(0, 255));
      ohl = pick_ihl();
      pkt[0][3:0] = 4'(ohl);
      if ($urandom_range(0, 3) != 0) pkt[0][7:4] = 4'h4;
      ohl = ohl * 4;
      src = sender_pool[$urandom_range(0, POOL_SIZE - 1)];
      for (int i = 0; i < 4; i++) pkt[12+i] = src[8*(3-i) +: 8];
      r = $urandom_range(0, 9);
      if (r < 4) kind = TYPE_ECHO_REPLY;
      else if (r < 8) kind = trm_pkg::TYPE_TIME_EXCEEDED;
      else if (r == 8) kind = trm_pkg::TYPE_ECHO;
      else kind = 8'($urandom_range(0, 255));
      pkt[ohl] = kind;
      if (kind == trm_pkg::TYPE_TIME_EXCEEDED) begin
         base = ohl + int'(trm_pkg::QUOTE_SKIP);
         r = pick_ihl();
         pkt[base] = {4'h4, 4'(r)};
         fpos = base + r * 4 + int'(trm_pkg::ID_OFFSET);
      end else begin
         fpos = ohl + int'(trm_pkg::ID_OFFSET);
      end
      id = ($urandom_range(0, 3) != 0) ? cfg_id : 16'($urandom_range(0, 65535));
      ttl = ($urandom_range(0, 3) != 0) ? cfg_ttl : 14'($urandom_range(0, 16383));
      pkt[fpos] = id[7:0];
      pkt[fpos+1] = id[15:8];
      pkt[fpos+2] = {ttl[5:0], 2'($urandom_range(0, 3))};
      pkt[fpos+3] = ttl[13:6];
      full = ((fpos + 4 > 16) ? fpos + 4 : 16) + $urandom_range(0, 8);
      r = $urandom_range(0, 39);
      if (r < 3) len = $urandom_range(1, full);
      else if (r == 3) len = $urandom_range(256, 300);
      else len = full;
      for (int i = 0; i < len; i++) add_item(trm_pkg::CMD_BYTE, pkt[i], i == len - 1);
      count = len;
   endtask

   task automatic write_csr(input logic [trm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == trm_pkg::CSR_PROBE_ID) cfg_id = val;
      else cfg_ttl = val[13:0];
   endtask

   task automatic wait_drained();
      while (!(byte_feed.size() == 0 && !req_tvalid && pending_replies.size() == 0))
         @(posedge clock);
   endtask

   initial begin : stimulus
      int gap_plan [0:NUM_PHASES-1];
      int stall_plan [0:NUM_PHASES-1];
      int queued;
      int n;
      int r;
      gap_plan = '{0, 3, 8, 2, 0};
      stall_plan = '{0, 4, 12, 0, 6};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         queued = 0;
         if (ph > 0) begin
            wait_drained();
            repeat (8) @(posedge clock);
            unique case (ph)
               1: begin
                  write_csr(trm_pkg::CSR_PROBE_ID, 16'hFFFF);
                  write_csr(trm_pkg::CSR_PROBE_TTL, 16'hFFFF);
               end
               2: begin
                  write_csr(trm_pkg::CSR_PROBE_ID, 16'h0000);
                  write_csr(trm_pkg::CSR_PROBE_TTL, 16'h0000);
               end
               default: begin
                  write_csr(trm_pkg::CSR_PROBE_ID, 16'($urandom_range(0, 65535)));
                  write_csr(trm_pkg::CSR_PROBE_TTL, 16'($urandom_range(0, 65535)));
               end
            endcase
         end
         tx_gap_max = gap_plan[ph];
         rx_stall_max = stall_plan[ph];
         sender_pool[0] = 32'h0000_0000;
         sender_pool[1] = 32'hFFFF_FFFF;
         for (int i = 2; i < POOL_SIZE; i++) sender_pool[i] = $urandom;

         if (ph == 0) begin
            add_item(trm_pkg::CMD_CLEAR, 8'hFF, 1'b1);
            add_item(trm_pkg::CMD_BYTE, 8'hFF, 1'b1);
            for (int i = 0; i < 16; i++)
               add_item(trm_pkg::CMD_BYTE, compact_reply[i], i == 15);
            for (int i = 0; i < 8; i++)
               add_item(trm_pkg::CMD_BYTE, compact_reply[i], i == 7);
            queued = 26;
         end

         while (queued < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               add_packet(n);
               queued += n;
            end else if (r < 88) begin
               add_item(trm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
               queued++;
            end else if (r < 94) begin
               n = $urandom_range(1, 20);
               for (int i = 0; i < n; i++)
                  add_item(trm_pkg::CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0);
               add_item(trm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
               queued += n + 1;
            end else begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++)
                  add_item(trm_pkg::CMD_BYTE, 8'($urandom_range(0, 255)), i == n - 1);
               queued += n;
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Covered %0d input transactions (%0d clears) and %0d result transactions,",
               n_items, n_clears, n_results);
      $display("with %0d matches and %0d new senders over %0d probe settings.",
               n_matches, n_fresh, NUM_PHASES);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
sv/trm_pkg.sv
sv/trm_parser.sv
sv/traceroute_reply_matcher_unit.sv
sv/trm_checker.sv
verif/traceroute_reply_matcher_unit_tb.sv
